FILE: hdl/ihw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Intel HEX record writer package
// Shared widths, character codes, the command passed from the front end to
// the character sequencer, and the nibble-to-ASCII conversion.
// ----------------------------------------------------------------------------
package ihw_pkg;

    // Default number of data bytes in one record.
    localparam int LINE_BYTES_DEF = 16;
    // Default depth of the command queue between front end and sequencer.
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int DATA_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int LEN_W   = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEWLINE_MODE = 1'd1;

    // ASCII codes used directly: colon, line endings and the digits 0, 1 and F.
    localparam logic [CHAR_W-1:0] CH_COLON = 7'h3A;
    localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_ONE   = 7'h31;
    localparam logic [CHAR_W-1:0] CH_F     = 7'h46;

    // One command per accepted data byte: everything the sequencer needs
    // to spell out the characters that this byte causes.
    typedef struct packed {
        logic                 hdr;     // a record header comes first
        logic [DATA_W-1:0]    width;   // byte count of the record
        logic [LEN_W-1:0]     addr;    // load address of the record
        logic [DATA_W-1:0]    data;    // the data byte itself
        logic                 close;   // checksum and line ending follow
        logic [DATA_W-1:0]    check;   // checksum of the record
        logic                 eof;     // end-of-file record follows
        logic                 crlf;    // line ending is CR LF
    } t_cmd;

    // Upper-case hex digit of a nibble.
    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] c;
        if (nib < 4'd10) begin
            c = 7'h30 + {3'd0, nib};
        end else begin
            c = 7'h37 + {3'd0, nib};
        end
        return c;
    endfunction

endpackage : ihw_pkg
`default_nettype wire

FILE: hdl/ihw_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Intel HEX record writer channel interfaces
// Valid/ready channels for data bytes in, characters out and register writes.
// ----------------------------------------------------------------------------
interface ihw_in_if import ihw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface : ihw_in_if

interface ihw_out_if import ihw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ascii_char;
    logic              last_of_run;
    logic              file_done;

    modport source (output valid, output ascii_char, output last_of_run,
                    output file_done, input ready);
    modport sink   (input valid, input ascii_char, input last_of_run,
                    input file_done, output ready);
endinterface : ihw_out_if

interface ihw_cfg_if import ihw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [LEN_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : ihw_cfg_if
`default_nettype wire

FILE: hdl/ihw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Intel HEX record writer front end
// Holds the configuration and the record state, classifies each data byte
// (header, data only, record close, end of file) and issues a command.
// ----------------------------------------------------------------------------
module ihw_front import ihw_pkg::*; #(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ihw_in_if.sink       i_in,
    ihw_cfg_if.sink      i_cfg,
    input  wire          i_q_ready,
    output logic         o_q_push,
    output t_cmd         o_q_cmd
);

    logic [LEN_W-1:0]  r_total;
    logic              r_crlf;
    logic [LEN_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_left;
    logic [DATA_W-1:0] r_sum;

    logic [LEN_W:0]    n_remaining;
    logic              n_hdr;
    logic [DATA_W-1:0] n_width;
    logic [DATA_W-1:0] n_sum;
    logic [DATA_W-1:0] n_left;
    logic [LEN_W-1:0]  n_pos;
    logic              n_close;
    logic              n_eof;

    // Register writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= LEN_W'(1);
            r_crlf  <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TOTAL_LENGTH: r_total <= i_cfg.data;
                CFG_NEWLINE_MODE: r_crlf  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Classify the byte: open a record if none is open, count it, and see
    // whether it closes the record and the image.
    always_comb begin
        n_remaining = {1'b0, r_total - r_pos};
        if (n_remaining == '0) begin
            n_remaining = {1'b1, {LEN_W{1'b0}}};
        end
        n_hdr = (r_left == '0);
        if (n_remaining < (LEN_W+1)'(LINE_BYTES)) begin
            n_width = n_remaining[DATA_W-1:0];
        end else begin
            n_width = DATA_W'(LINE_BYTES);
        end
        if (n_hdr) begin
            n_sum  = n_width + r_pos[LEN_W-1:DATA_W] + r_pos[DATA_W-1:0]
                     + i_in.data_byte;
            n_left = n_width - DATA_W'(1);
        end else begin
            n_sum  = r_sum + i_in.data_byte;
            n_left = r_left - DATA_W'(1);
        end
        n_pos   = r_pos + LEN_W'(1);
        n_close = (n_left == '0);
        n_eof   = n_close && (n_pos == r_total);
    end

    assign i_in.ready = i_q_ready;
    assign o_q_push   = i_in.valid && i_q_ready;

    always_comb begin
        o_q_cmd.hdr   = n_hdr;
        o_q_cmd.width = n_width;
        o_q_cmd.addr  = r_pos;
        o_q_cmd.data  = i_in.data_byte;
        o_q_cmd.close = n_close;
        o_q_cmd.check = DATA_W'(0) - n_sum;
        o_q_cmd.eof   = n_eof;
        o_q_cmd.crlf  = r_crlf;
    end

    // Record state advances on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_left <= '0;
            r_sum  <= '0;
        end else if (o_q_push) begin
            if (n_eof) begin
                r_pos  <= '0;
                r_left <= '0;
                r_sum  <= '0;
            end else begin
                r_pos  <= n_pos;
                r_left <= n_left;
                r_sum  <= n_close ? '0 : n_sum;
            end
        end
    end

endmodule : ihw_front
`default_nettype wire

FILE: hdl/ihw_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Intel HEX record writer command queue
// Small first-in first-out store that decouples the front end from the
// character sequencer.
// ----------------------------------------------------------------------------
module ihw_queue import ihw_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_cmd  i_cmd,
    output logic  o_ready,
    input  wire   i_pop,
    output logic  o_valid,
    output t_cmd  o_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    // Storage is written at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule : ihw_queue
`default_nettype wire

FILE: hdl/ihw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Intel HEX record writer character sequencer
// Walks through the characters of the command at the head of the queue,
// one character per cycle into an output register while it is free.
// ----------------------------------------------------------------------------
module ihw_back import ihw_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_q_valid,
    input  t_cmd         i_q_cmd,
    output logic         o_q_pop,
    ihw_out_if.source    o_out
);

    localparam int STEP_W = 5;

    // Character positions of one command.
    localparam logic [STEP_W-1:0] S_COLON  = 5'd0;
    localparam logic [STEP_W-1:0] S_WH     = 5'd1;
    localparam logic [STEP_W-1:0] S_WL     = 5'd2;
    localparam logic [STEP_W-1:0] S_A3     = 5'd3;
    localparam logic [STEP_W-1:0] S_A2     = 5'd4;
    localparam logic [STEP_W-1:0] S_A1     = 5'd5;
    localparam logic [STEP_W-1:0] S_A0     = 5'd6;
    localparam logic [STEP_W-1:0] S_T1     = 5'd7;
    localparam logic [STEP_W-1:0] S_T0     = 5'd8;
    localparam logic [STEP_W-1:0] S_DH     = 5'd9;
    localparam logic [STEP_W-1:0] S_DL     = 5'd10;
    localparam logic [STEP_W-1:0] S_CH     = 5'd11;
    localparam logic [STEP_W-1:0] S_CL     = 5'd12;
    localparam logic [STEP_W-1:0] S_CR     = 5'd13;
    localparam logic [STEP_W-1:0] S_LF     = 5'd14;
    localparam logic [STEP_W-1:0] S_ECOLON = 5'd15;
    localparam logic [STEP_W-1:0] S_E0     = 5'd16;
    localparam logic [STEP_W-1:0] S_E6     = 5'd22;
    localparam logic [STEP_W-1:0] S_E7     = 5'd23;
    localparam logic [STEP_W-1:0] S_E8     = 5'd24;
    localparam logic [STEP_W-1:0] S_E9     = 5'd25;
    localparam logic [STEP_W-1:0] S_ECR    = 5'd26;
    localparam logic [STEP_W-1:0] S_ELF    = 5'd27;

    logic              r_mid;
    logic [STEP_W-1:0] r_step;
    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic              r_done;

    logic [STEP_W-1:0] w_step;
    logic [STEP_W-1:0] w_next;
    logic              w_last;
    logic [CHAR_W-1:0] w_char;
    logic              w_adv;

    // Current position: a fresh command starts at its header or its data.
    always_comb begin
        if (r_mid) begin
            w_step = r_step;
        end else begin
            w_step = i_q_cmd.hdr ? S_COLON : S_DH;
        end
    end

    // Next position, skipping the parts this command does not have.
    always_comb begin
        w_next = w_step + STEP_W'(1);
        w_last = 1'b0;
        case (w_step)
            S_DL: w_last = !i_q_cmd.close;
            S_CL: w_next = i_q_cmd.crlf ? S_CR : S_LF;
            S_LF: begin
                w_last = !i_q_cmd.eof;
                w_next = S_ECOLON;
            end
            S_E9: w_next = i_q_cmd.crlf ? S_ECR : S_ELF;
            S_ELF: w_last = 1'b1;
            default: ;
        endcase
    end

    // Character at the current position.
    always_comb begin
        case (w_step) inside
            S_COLON, S_ECOLON: w_char = CH_COLON;
            S_WH:              w_char = hex_char(i_q_cmd.width[7:4]);
            S_WL:              w_char = hex_char(i_q_cmd.width[3:0]);
            S_A3:              w_char = hex_char(i_q_cmd.addr[15:12]);
            S_A2:              w_char = hex_char(i_q_cmd.addr[11:8]);
            S_A1:              w_char = hex_char(i_q_cmd.addr[7:4]);
            S_A0:              w_char = hex_char(i_q_cmd.addr[3:0]);
            S_T1, S_T0:        w_char = CH_ZERO;
            S_DH:              w_char = hex_char(i_q_cmd.data[7:4]);
            S_DL:              w_char = hex_char(i_q_cmd.data[3:0]);
            S_CH:              w_char = hex_char(i_q_cmd.check[7:4]);
            S_CL:              w_char = hex_char(i_q_cmd.check[3:0]);
            S_CR, S_ECR:       w_char = CH_CR;
            S_LF, S_ELF:       w_char = CH_LF;
            [S_E0:S_E6]:       w_char = CH_ZERO;
            S_E7:              w_char = CH_ONE;
            S_E8, S_E9:        w_char = CH_F;
            default:           w_char = CH_LF;
        endcase
    end

    // A waiting command and a free output register make a character.
    assign w_adv   = i_q_valid && (!r_valid || o_out.ready);
    assign o_q_pop = w_adv && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid   <= 1'b0;
            r_step  <= S_COLON;
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= 1'b1;
            r_mid   <= !w_last;
            r_step  <= w_next;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_char <= w_char;
            r_last <= w_last;
            r_done <= w_last && i_q_cmd.eof;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.ascii_char  = r_char;
    assign o_out.last_of_run = r_last;
    assign o_out.file_done   = r_done;

endmodule : ihw_back
`default_nettype wire

FILE: hdl/intel_hex_record_writer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A byte's first character goes through the command queue and output register.
// Throughput: one character per cycle from the sequencer while the output is
// ready; a byte gives 2 to 28 characters, about 3 on average in 16-byte records.
// The command queue takes bytes while earlier characters are still being sent.
// Synchronous active-low reset: total length 1, CR LF line endings, address 0.
// ----------------------------------------------------------------------------
// Intel HEX record writer
// Turns a stream of image bytes into Intel HEX text, one character per
// transaction, with the end-of-file record after the last byte.
// ----------------------------------------------------------------------------
module intel_hex_record_writer_top import ihw_pkg::*; #(
    parameter int LINE_BYTES  = LINE_BYTES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ihw_in_if.sink     i_in,
    ihw_cfg_if.sink    i_cfg,
    ihw_out_if.source  o_out
);

    logic q_push;
    logic q_ready;
    logic q_pop;
    logic q_valid;
    t_cmd q_in_cmd;
    t_cmd q_head_cmd;

    // Classification and record bookkeeping.
    ihw_front #(
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_cmd   (q_in_cmd)
    );

    // Command queue.
    ihw_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_head_cmd)
    );

    // Character sequencer.
    ihw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_head_cmd),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule : intel_hex_record_writer_top
`default_nettype wire

FILE: verif/intel_hex_record_writer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record writer testbench
// Feeds image bytes into the writer and checks every character of the
// resulting HEX text against an internal encoder: record headers, data
// digits, checksums, line endings and the end-of-file record, with the
// last-of-run and file-done flags. Directed images come first, then random
// images under random idling on both sides, then one image with a zero
// length, which stands for 65536 bytes.
// ----------------------------------------------------------------------------
module intel_hex_record_writer_top_test;
    import ihw_pkg::*;

    localparam int  RESET_CYCLES = 9;
    localparam int  REC_BYTES    = LINE_BYTES_DEF;
    localparam int  DRAIN_CYCLES = 8;
    localparam int  RANDOM_ITEMS = 400;
    localparam int  MAX_REPORTS  = 10;
    localparam real RUN_LIMIT_NS = 40_000_000.0;

    localparam logic [7:0]        REC_DATA = 8'h00;
    localparam logic [7:0]        REC_EOF  = 8'h01;
    localparam logic [7:0]        EOF_SUM  = 8'hFF;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h41;

    // One character of the HEX text with its two flags.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              done;
    } text_char_t;

    logic i_clk;
    logic i_rst_n;

    ihw_in_if  in_if ();
    ihw_cfg_if cfg_if ();
    ihw_out_if out_if ();

    intel_hex_record_writer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Encoder state, kept in step with the writer.
    logic [LEN_W-1:0]  img_len  = 16'd1;
    logic              crlf_on  = 1'b1;
    logic [LEN_W-1:0]  img_pos  = 16'd0;
    logic [7:0]        rec_left = 8'd0;
    logic [7:0]        rec_sum  = 8'd0;

    text_char_t expected_chars[$];
    text_char_t run_buf[$];

    // Idling controls and run statistics.
    bit tx_idle_on  = 1'b0;
    bit rx_idle_on  = 1'b0;
    int hold_left   = 0;
    int rx_stall    = 0;
    int err_count   = 0;
    int bytes_sent  = 0;
    int chars_seen  = 0;
    int images_done = 0;

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = ~i_clk;
    end

    // Gap length for either side: mostly short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [CHAR_W-1:0] nibble_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return CH_ZERO + {3'b000, n};
        end
        return CH_A + {3'b000, n - 4'd10};
    endfunction

    function automatic void add_char(input logic [CHAR_W-1:0] c);
        text_char_t t;
        t.ch   = c;
        t.last = 1'b0;
        t.done = 1'b0;
        run_buf.push_back(t);
    endfunction

    // Two hex digits, optionally folded into the record checksum.
    function automatic void add_hex(input logic [7:0] v, input logic summed);
        if (summed) begin
            rec_sum = rec_sum + v;
        end
        add_char(nibble_char(v[7:4]));
        add_char(nibble_char(v[3:0]));
    endfunction

    function automatic void add_eol();
        if (crlf_on) begin
            add_char(CH_CR);
        end
        add_char(CH_LF);
    endfunction

    // Works out the characters that one image byte causes and queues them.
    function automatic void encode_byte(input logic [7:0] b);
        logic [16:0] remain;
        logic [7:0]  width;
        logic        eof;
        text_char_t  tail;
        eof = 1'b0;
        run_buf.delete();
        if (rec_left == 8'd0) begin
            remain = {1'b0, img_len - img_pos};
            if (remain == 17'd0) begin
                remain = 17'h10000;
            end
            width = (remain < REC_BYTES) ? remain[7:0] : 8'(REC_BYTES);
            rec_sum = 8'd0;
            add_char(CH_COLON);
            add_hex(width, 1'b1);
            add_hex(img_pos[15:8], 1'b1);
            add_hex(img_pos[7:0], 1'b1);
            add_hex(REC_DATA, 1'b1);
            rec_left = width;
        end
        add_hex(b, 1'b1);
        if (rec_left != 8'd0) begin
            rec_left = rec_left - 8'd1;
        end
        img_pos = img_pos + 16'd1;
        // Close the record, and the image too when its length is reached.
        if (rec_left == 8'd0) begin
            add_hex(8'h00 - rec_sum, 1'b0);
            add_eol();
            rec_sum = 8'd0;
            if (img_pos == img_len) begin
                add_char(CH_COLON);
                add_hex(8'h00, 1'b0);
                add_hex(8'h00, 1'b0);
                add_hex(8'h00, 1'b0);
                add_hex(REC_EOF, 1'b0);
                add_hex(EOF_SUM, 1'b0);
                add_eol();
                img_pos  = 16'd0;
                rec_left = 8'd0;
                eof      = 1'b1;
            end
        end
        tail = run_buf[run_buf.size() - 1];
        tail.last = 1'b1;
        tail.done = eof;
        run_buf[run_buf.size() - 1] = tail;
        foreach (run_buf[i]) begin
            expected_chars.push_back(run_buf[i]);
        end
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [LEN_W-1:0] val);
        if (idx == CFG_TOTAL_LENGTH) begin
            img_len = val;
        end else if (idx == CFG_NEWLINE_MODE) begin
            crlf_on = val[0];
        end
    endfunction

    // A new length that the open image can still reach without a wrap.
    function automatic logic [LEN_W-1:0] safe_length();
        int lo;
        lo = int'(img_pos) + int'(rec_left);
        if (rec_left == 8'd0) begin
            lo = lo + 1;
        end
        if ($urandom_range(0, 4) == 0) begin
            return LEN_W'(lo + $urandom_range(100, 300));
        end
        return LEN_W'(lo + $urandom_range(0, 40));
    endfunction

    // Register write: one transaction on the configuration channel.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [LEN_W-1:0] val);
        logic acc;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do begin
            @(negedge i_clk);
            acc = cfg_if.ready;
            @(posedge i_clk);
        end while (!acc);
        cfg_if.valid <= 1'b0;
        apply_register(idx, val);
        @(posedge i_clk);
    endtask

    // Offers one image byte, after an optional gap, until it is taken.
    task automatic send_byte(input logic [7:0] b);
        int   gap;
        logic acc;
        gap = (tx_idle_on && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        encode_byte(b);
        do begin
            @(negedge i_clk);
            acc = in_if.ready;
            @(posedge i_clk);
        end while (!acc);
        bytes_sent++;
    endtask

    // Stops offering bytes and waits for every queued character.
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Sends random bytes until the open image has been closed.
    task automatic finish_image();
        while (img_pos != 16'd0 || rec_left != 8'd0) begin
            send_byte(8'($urandom_range(0, 255)));
        end
        wait_drain();
    endtask

    // Reset values: one-byte images with CR LF endings, and a fresh image
    // at address zero after each end record.
    task automatic test_reset_defaults();
        send_byte(8'h5A);
        send_byte(8'hA5);
        wait_drain();
    endtask

    // Shortest length written explicitly, with LF endings and extreme bytes.
    task automatic test_short_images();
        write_reg(CFG_NEWLINE_MODE, 16'd0);
        write_reg(CFG_TOTAL_LENGTH, 16'd1);
        send_byte(8'hFF);
        send_byte(8'h00);
        wait_drain();
    endtask

    // Longest length, then a change in the middle of a record: the open
    // record keeps its announced count and the new length takes over after.
    task automatic test_length_change();
        logic [7:0] pattern [8];
        pattern = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
        write_reg(CFG_NEWLINE_MODE, 16'd1);
        write_reg(CFG_TOTAL_LENGTH, 16'hFFFF);
        foreach (pattern[i]) send_byte(pattern[i]);
        wait_drain();
        write_reg(CFG_TOTAL_LENGTH, 16'd18);
        foreach (pattern[i]) send_byte(~pattern[i]);
        wait_drain();
        send_byte(8'h3C);
        send_byte(8'hC3);
        wait_drain();
    endtask

    // Random images in phases with random settings and idling; one phase
    // holds the receiver off while the sender keeps offering bytes.
    task automatic test_random_images();
        int sent;
        int n;
        int phase;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_NEWLINE_MODE, 16'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 2) != 0) begin
                write_reg(CFG_TOTAL_LENGTH, safe_length());
            end
            n = $urandom_range(1, 40);
            if (phase == 3) begin
                hold_left  = 400;
                tx_idle_on = 1'b0;
                n = 40;
            end
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            sent = sent + n;
            wait_drain();
            phase++;
        end
        finish_image();
    endtask

    // A zero length stands for 65536 bytes, so two full records go out with
    // the image still open; a shorter length then closes it.
    task automatic test_length_wrap();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_reg(CFG_TOTAL_LENGTH, 16'd0);
        repeat (32) send_byte(8'($urandom_range(0, 255)));
        wait_drain();
        write_reg(CFG_TOTAL_LENGTH, 16'd40);
        finish_image();
    endtask

    // Receiver readiness: long hold-offs first, then random short stalls.
    always @(posedge i_clk) begin : char_ready
        if (hold_left != 0) begin
            out_if.ready <= 1'b0;
            hold_left--;
        end else if (rx_stall != 0) begin
            out_if.ready <= 1'b0;
            rx_stall--;
        end else begin
            out_if.ready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 99) < 20) begin
                rx_stall = gap_len();
            end
        end
    end

    // Compares each character transaction with the oldest expectation.
    // Outputs are stable by the falling edge, ahead of the accepting edge.
    always @(negedge i_clk) begin : char_check
        text_char_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            chars_seen++;
            if (out_if.file_done) begin
                images_done++;
            end
            if (expected_chars.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS) begin
                    $display("Unexpected character %02h (last %0b done %0b)",
                             out_if.ascii_char, out_if.last_of_run, out_if.file_done);
                end
            end else begin
                want = expected_chars.pop_front();
                if (want.ch !== out_if.ascii_char || want.last !== out_if.last_of_run
                        || want.done !== out_if.file_done) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("Mismatch at character %0d: expected %02h last %0b done %0b, got %02h last %0b done %0b",
                                 chars_seen, want.ch, want.last, want.done,
                                 out_if.ascii_char, out_if.last_of_run, out_if.file_done);
                    end
                end
            end
        end
    end

    // Overall time limit.
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d characters outstanding", expected_chars.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Test sequence.
    initial begin : test_sequence
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.data_byte <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= CFG_TOTAL_LENGTH;
        cfg_if.data     <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_short_images();
        test_length_change();
        test_random_images();
        test_length_wrap();

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            $display("%0d expected characters never arrived", expected_chars.size());
        end
        $display("Encoded %0d bytes into %0d characters over %0d images, with both line",
                 bytes_sent, chars_seen, images_done);
        $display("endings, lengths from 1 to 65536 and mid-record length changes.");
        if (err_count == 0 && expected_chars.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule : intel_hex_record_writer_top_test

FILE: sim.f
hdl/ihw_pkg.sv
hdl/ihw_if.sv
hdl/ihw_front.sv
hdl/ihw_queue.sv
hdl/ihw_back.sv
hdl/intel_hex_record_writer_top.sv
verif/intel_hex_record_writer_top_test.sv
